@@ hdl/irbcfd_pkg.sv @@
// Shared constants, types and register codes for the IR beam calibrate and detect block.
`default_nettype none

package irbcfd_pkg;

  localparam int NUM_SENSORS = 6;
  localparam int ADC_BITS    = 10;
  localparam int FRAC_BITS   = 8;
  localparam int FV_W        = ADC_BITS + FRAC_BITS;
  localparam int THR_W       = 15;
  localparam int CNT_W       = 11;
  localparam int IDX_W       = 3;
  localparam int TOTAL_W     = 5;
  localparam int COUNT_W     = 3;
  localparam int POS_W       = 9;
  localparam int DIV_W       = 6;
  localparam int QSTEPS      = 9;
  localparam int ALPHA_W     = 9;
  localparam int LIMIT_W     = 10;
  localparam int PROD_W      = FV_W + ALPHA_W;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic signed [THR_W-1:0] THRESH_RESET = 15'sd10000;
  localparam logic [ALPHA_W-1:0]      ALPHA_ONE    = 9'd256;

  localparam logic [1:0] REG_DEADZONE = 2'd0;
  localparam logic [1:0] REG_ALPHA    = 2'd1;
  localparam logic [1:0] REG_SKIP     = 2'd2;
  localparam logic [1:0] REG_ACQUIRE  = 2'd3;

  typedef logic [ADC_BITS-1:0] sample_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] deadzone;
    logic [ALPHA_W-1:0] alpha;
    logic [LIMIT_W-1:0] skip_limit;
    logic [LIMIT_W-1:0] acquire_limit;
  } cfg_t;

  typedef struct packed {
    logic             capture;
    logic             clear_all;
    logic             mul_en;
    logic             upd_en;
    logic [IDX_W-1:0] sel;
    logic             div_init;
    logic             div_step;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/irbcfd_if.sv @@
// Valid/ready channel interfaces for the sample frame items and the detection result items.
`default_nettype none

interface irbcfd_frame_if;
  import irbcfd_pkg::*;

  logic    valid;
  logic    ready;
  logic    action;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;
  sample_t sample_4;
  sample_t sample_5;

  modport source (
    output valid, action, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
    input  ready
  );
  modport sink (
    input  valid, action, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
    output ready
  );
endinterface

interface irbcfd_result_if;
  import irbcfd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [NUM_SENSORS-1:0] trigger_mask;
  logic [POS_W-1:0]       hand_position;
  logic                   all_calibrated;

  modport source (
    output valid, trigger_mask, hand_position, all_calibrated,
    input  ready
  );
  modport sink (
    input  valid, trigger_mask, hand_position, all_calibrated,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/ir_beam_calibrate_filter_detect.sv @@
// Top level: configuration registers, channel wiring, controller and datapath.
// A sample frame item walks the sensors and, when any sensor triggers, runs the divider;
// a recalibrate item clears the sensor state and gives its result without either.
// One item is in work at a time; the sensors are walked one per cycle through one shared
// multiplier pair, then, when any sensor triggers, a nine-step restoring divider.
// Synchronous reset restores the register defaults and returns all six sensors to calibration.
`default_nettype none

module ir_beam_calibrate_filter_detect (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irbcfd_pkg::ADDR_W-1:0] paddr,
  input  logic [irbcfd_pkg::DATA_W-1:0] pwdata,
  output logic [irbcfd_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  irbcfd_frame_if.sink                  frame,
  irbcfd_result_if.source               result
);
  import irbcfd_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;
  logic    wr_en;
  logic [NUM_SENSORS-1:0][ADC_BITS-1:0] samples;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone      <= '0;
      cfg.alpha         <= ALPHA_ONE;
      cfg.skip_limit    <= LIMIT_W'(8);
      cfg.acquire_limit <= LIMIT_W'(64);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_DEADZONE: cfg.deadzone      <= pwdata[LIMIT_W-1:0];
        REG_ALPHA:    cfg.alpha         <= pwdata[ALPHA_W-1:0];
        REG_SKIP:     cfg.skip_limit    <= pwdata[LIMIT_W-1:0];
        REG_ACQUIRE:  cfg.acquire_limit <= pwdata[LIMIT_W-1:0];
        default:      cfg.deadzone      <= cfg.deadzone;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEADZONE: prdata = DATA_W'(cfg.deadzone);
      REG_ALPHA:    prdata = DATA_W'(cfg.alpha);
      REG_SKIP:     prdata = DATA_W'(cfg.skip_limit);
      REG_ACQUIRE:  prdata = DATA_W'(cfg.acquire_limit);
      default:      prdata = '0;
    endcase
  end

  assign samples[0] = frame.sample_0;
  assign samples[1] = frame.sample_1;
  assign samples[2] = frame.sample_2;
  assign samples[3] = frame.sample_3;
  assign samples[4] = frame.sample_4;
  assign samples[5] = frame.sample_5;

  irbcfd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame.valid),
    .frame_action (frame.action),
    .frame_ready  (frame.ready),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .st           (st),
    .cmd          (cmd)
  );

  irbcfd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .frame_samples  (samples),
    .st             (st),
    .trigger_mask   (result.trigger_mask),
    .hand_position  (result.hand_position),
    .all_calibrated (result.all_calibrated)
  );

  a_no_trigger_no_position: assert property (
    @(posedge clk) disable iff (rst)
    (result.valid && (result.trigger_mask == '0)) |-> (result.hand_position == '0)
  ) else $error("Hand position is nonzero while no sensor triggers.");

  a_trigger_position_range: assert property (
    @(posedge clk) disable iff (rst)
    (result.valid && (result.trigger_mask != '0)) |->
      ((result.hand_position != '0) && (result.hand_position <= POS_W'(256)))
  ) else $error("Hand position is out of range for a triggered mask.");

  a_one_item_in_work: assert property (
    @(posedge clk) disable iff (rst)
    (frame.valid && frame.ready) |=> !frame.ready
  ) else $error("A new item was offered acceptance while one is in work.");

endmodule

`default_nettype wire

@@ hdl/irbcfd_dp.sv @@
// Datapath: per-sensor calibration state, filter multipliers, trigger accumulation and divider.
`default_nettype none

module irbcfd_dp (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  irbcfd_pkg::cfg_t                                     cfg,
  input  irbcfd_pkg::cmd_t                                     cmd,
  input  logic [irbcfd_pkg::NUM_SENSORS-1:0][irbcfd_pkg::ADC_BITS-1:0] frame_samples,
  output irbcfd_pkg::status_t                                  st,
  output logic [irbcfd_pkg::NUM_SENSORS-1:0]                   trigger_mask,
  output logic [irbcfd_pkg::POS_W-1:0]                         hand_position,
  output logic                                                 all_calibrated
);
  import irbcfd_pkg::*;

  sample_t                   samp     [NUM_SENSORS];
  logic signed [THR_W-1:0]   thr      [NUM_SENSORS];
  logic [FV_W-1:0]           fv       [NUM_SENSORS];
  logic [CNT_W-1:0]          skip_cnt [NUM_SENSORS];
  logic [CNT_W-1:0]          acq_cnt  [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]    cal;

  logic [IDX_W-1:0]          m_idx;
  sample_t                   m_s;
  logic [PROD_W-1:0]         prod_new;
  logic [PROD_W-1:0]         prod_old;

  logic [NUM_SENSORS-1:0]    mask;
  logic [TOTAL_W-1:0]        total;
  logic [COUNT_W-1:0]        count;

  logic [DIV_W-1:0]          div_r;
  logic [DIV_W-1:0]          div_d;
  logic [QSTEPS-1:0]         div_sh;
  logic [QSTEPS-1:0]         div_q;

  logic [ALPHA_W-1:0]        a_eff;
  logic [ALPHA_W-1:0]        a_inv;
  sample_t                   mul_s;
  logic [PROD_W:0]           sum;
  logic [FV_W-1:0]           fv_filt;
  logic signed [THR_W-1:0]   thr_u;
  logic signed [THR_W-1:0]   s_thr;
  logic signed [THR_W-1:0]   min_thr;
  logic signed [THR_W-1:0]   thr_cal;
  logic [THR_W+FRAC_BITS-2:0] thr_scaled;
  logic [CNT_W-1:0]          acq_inc;
  logic [CNT_W-1:0]          skip_inc;
  logic                      skipping;
  logic                      acq_done;
  logic                      trig;
  logic [DIV_W:0]            div_t;
  logic                      div_ge;

  assign a_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign a_inv = ALPHA_ONE - a_eff;
  assign mul_s = samp[cmd.sel];

  assign sum     = (PROD_W+1)'(prod_new) + (PROD_W+1)'(prod_old);
  assign fv_filt = sum[FRAC_BITS +: FV_W];

  assign thr_u      = thr[m_idx];
  assign s_thr      = signed'(THR_W'(m_s));
  assign min_thr    = (s_thr < thr_u) ? s_thr : thr_u;
  assign thr_cal    = min_thr - signed'(THR_W'(cfg.deadzone));
  assign thr_scaled = {thr_u[THR_W-2:0], {FRAC_BITS{1'b0}}};
  assign acq_inc    = acq_cnt[m_idx] + CNT_W'(1);
  assign skip_inc   = skip_cnt[m_idx] + CNT_W'(1);
  assign skipping   = !(skip_cnt[m_idx] > CNT_W'(cfg.skip_limit));
  assign acq_done   = acq_inc > CNT_W'(cfg.acquire_limit);
  assign trig       = cal[m_idx] && (thr_u > 15'sd0) &&
                      ((THR_W+FRAC_BITS-1)'(fv_filt) < thr_scaled);

  assign div_t  = {div_r, div_sh[QSTEPS-1]};
  assign div_ge = div_t >= {1'b0, div_d};

  assign st.count_zero = (count == '0);

  always_ff @(posedge clk) begin
    if (rst || (cmd.capture && cmd.clear_all)) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        thr[i]      <= THRESH_RESET;
        fv[i]       <= '0;
        skip_cnt[i] <= '0;
        acq_cnt[i]  <= '0;
      end
      cal <= '0;
    end else if (cmd.upd_en) begin
      if (cal[m_idx]) begin
        fv[m_idx] <= fv_filt;
      end else if (!skipping) begin
        acq_cnt[m_idx] <= acq_inc;
        if (acq_done) begin
          fv[m_idx]  <= {m_s, {FRAC_BITS{1'b0}}};
          thr[m_idx] <= thr_cal;
          cal[m_idx] <= 1'b1;
        end else begin
          thr[m_idx] <= min_thr;
        end
      end else begin
        skip_cnt[m_idx] <= skip_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask  <= '0;
      total <= '0;
      count <= '0;
    end else if (cmd.capture) begin
      mask  <= '0;
      total <= '0;
      count <= '0;
    end else if (cmd.upd_en && trig) begin
      mask[m_idx] <= 1'b1;
      total       <= total + TOTAL_W'(m_idx) + TOTAL_W'(1);
      count       <= count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        samp[i] <= frame_samples[i];
      end
    end
    if (cmd.mul_en) begin
      m_idx    <= cmd.sel;
      m_s      <= mul_s;
      prod_new <= PROD_W'({mul_s, {FRAC_BITS{1'b0}}}) * PROD_W'(a_eff);
      prod_old <= PROD_W'(fv[cmd.sel]) * PROD_W'(a_inv);
    end
    if (cmd.div_init) begin
      div_r  <= DIV_W'(total >> 1);
      div_d  <= DIV_W'(count) * DIV_W'(NUM_SENSORS);
      div_sh <= {total[0], {FRAC_BITS{1'b0}}};
    end else if (cmd.div_step) begin
      div_r  <= div_ge ? DIV_W'(div_t - {1'b0, div_d}) : div_t[DIV_W-1:0];
      div_q  <= {div_q[QSTEPS-2:0], div_ge};
      div_sh <= div_sh << 1;
    end
    if (cmd.out_load) begin
      trigger_mask   <= mask;
      hand_position  <= (count == '0) ? '0 : div_q;
      all_calibrated <= &cal;
    end
  end

endmodule

`default_nettype wire

@@ hdl/irbcfd_ctrl.sv @@
// Controller: sequences the sensor walk, the divider steps and the result handoff.
`default_nettype none

module irbcfd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  input  logic                frame_action,
  output logic                frame_ready,
  input  logic                result_ready,
  output logic                result_valid,
  input  irbcfd_pkg::status_t st,
  output irbcfd_pkg::cmd_t    cmd
);
  import irbcfd_pkg::*;

  localparam int CW = 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SENS  = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          result_valid_next;

  assign frame_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (frame_valid) begin
          cmd.capture   = 1'b1;
          cmd.clear_all = frame_action;
          cnt_next      = '0;
          state_next    = frame_action ? S_DONE : S_SENS;
        end
      end
      S_SENS: begin
        cmd.mul_en = (cnt < CW'(NUM_SENSORS));
        cmd.upd_en = (cnt != '0);
        cmd.sel    = cmd.mul_en ? cnt[IDX_W-1:0] : '0;
        cnt_next   = cnt + CW'(1);
        if (cnt == CW'(NUM_SENSORS)) begin
          state_next = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = st.count_zero ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CW'(1);
        if (cnt == CW'(QSTEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign result_valid_next = cmd.out_load | (result_valid & ~result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the IR beam detect block: directed and random frames against a sensor predictor.
module tb_top;
  import irbcfd_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 40;
  localparam int SCENE_PHASES   = 10;
  localparam int SCENE_FRAMES   = 105;

  typedef struct {
    logic    action;
    sample_t smp [NUM_SENSORS];
  } frame_item_t;

  typedef struct packed {
    logic [NUM_SENSORS-1:0] mask;
    logic [POS_W-1:0]       pos;
    logic                   allcal;
  } detect_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  irbcfd_frame_if  frame_ch ();
  irbcfd_result_if result_ch ();

  ir_beam_calibrate_filter_detect dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .frame   (frame_ch),
    .result  (result_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [LIMIT_W-1:0] dz_cfg;
  logic [ALPHA_W-1:0] alpha_cfg;
  logic [LIMIT_W-1:0] skip_cfg;
  logic [LIMIT_W-1:0] acq_cfg;

  logic signed [THR_W-1:0] sens_thr  [NUM_SENSORS];
  logic [FV_W-1:0]         sens_fv   [NUM_SENSORS];
  logic [CNT_W-1:0]        sens_skip [NUM_SENSORS];
  logic [CNT_W-1:0]        sens_acq  [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]  sens_cal;

  detect_t expected_detect [$];
  sample_t scene_base [NUM_SENSORS];

  bit src_gaps = 1'b0;
  bit snk_gaps = 1'b0;
  bit hold_req = 1'b0;

  int n_items   = 0;
  int n_recal   = 0;
  int n_checked = 0;
  int n_trig    = 0;
  int n_allcal  = 0;
  int n_writes  = 0;
  int n_errors  = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_mismatch(string what, int exp_v, int act_v);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("mismatch at %0t: %s expected %0d, got %0d", $time, what, exp_v, act_v);
  endfunction

  function automatic void clear_sensor_model();
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sens_thr[i]  = THRESH_RESET;
      sens_fv[i]   = '0;
      sens_skip[i] = '0;
      sens_acq[i]  = '0;
    end
    sens_cal = '0;
  endfunction

  function automatic detect_t detect_frame(frame_item_t f);
    detect_t            d;
    logic [ALPHA_W-1:0] a_eff;
    logic [PROD_W:0]    acc;
    int                 total;
    int                 count;
    d = '0;
    total = 0;
    count = 0;
    if (f.action) begin
      clear_sensor_model();
      return d;
    end
    a_eff = (alpha_cfg > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (sens_cal[i]) begin
        acc = {f.smp[i], {FRAC_BITS{1'b0}}} * a_eff + sens_fv[i] * (ALPHA_ONE - a_eff);
        sens_fv[i] = FV_W'(acc >> FRAC_BITS);
        if (sens_thr[i] > 0 && int'(sens_fv[i]) < int'(sens_thr[i]) * (1 << FRAC_BITS)) begin
          d.mask[i] = 1'b1;
          total += i + 1;
          count++;
        end
      end else if (sens_skip[i] > CNT_W'(skip_cfg)) begin
        if (int'(f.smp[i]) < int'(sens_thr[i])) sens_thr[i] = THR_W'(f.smp[i]);
        sens_acq[i] = sens_acq[i] + 1'b1;
        if (sens_acq[i] > CNT_W'(acq_cfg)) begin
          sens_fv[i]  = {f.smp[i], {FRAC_BITS{1'b0}}};
          sens_cal[i] = 1'b1;
          sens_thr[i] = sens_thr[i] - THR_W'(dz_cfg);
        end
      end else begin
        sens_skip[i] = sens_skip[i] + 1'b1;
      end
    end
    if (count != 0) d.pos = POS_W'((total * 256) / (count * NUM_SENSORS));
    d.allcal = &sens_cal;
    return d;
  endfunction

  function automatic frame_item_t uniform_frame(logic act, sample_t v);
    frame_item_t f;
    f.action = act;
    foreach (f.smp[i]) f.smp[i] = v;
    return f;
  endfunction

  function automatic frame_item_t split_frame(logic [NUM_SENSORS-1:0] low_mask, sample_t low_v,
                                              sample_t high_v);
    frame_item_t f;
    f.action = 1'b0;
    foreach (f.smp[i]) f.smp[i] = low_mask[i] ? low_v : high_v;
    return f;
  endfunction

  // Mostly a steady scene around per-sensor baselines, with a hand dipping a run of sensors.
  function automatic frame_item_t scene_frame();
    frame_item_t f;
    int          r;
    int          lo;
    int          hi;
    int          v;
    r = $urandom_range(0, 99);
    f.action = (r < 3);
    if (r < 10) begin
      foreach (f.smp[i]) f.smp[i] = sample_t'($urandom);
      return f;
    end
    lo = $urandom_range(0, NUM_SENSORS - 1);
    hi = $urandom_range(lo, NUM_SENSORS - 1);
    foreach (f.smp[i]) begin
      if (r < 50 && i >= lo && i <= hi)
        v = $urandom_range(0, int'(scene_base[i]));
      else
        v = int'(scene_base[i]) + int'($urandom_range(0, 24)) - 12;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      f.smp[i] = sample_t'(v);
    end
    return f;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_writes++;
    case (idx)
      REG_DEADZONE: dz_cfg    = val[LIMIT_W-1:0];
      REG_ALPHA:    alpha_cfg = val[ALPHA_W-1:0];
      REG_SKIP:     skip_cfg  = val[LIMIT_W-1:0];
      REG_ACQUIRE:  acq_cfg   = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apb_read(input logic [1:0] idx, input logic [DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) note_mismatch("register readback", int'(want), int'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_frames();
    frame_ch.valid <= 1'b0;
    while (expected_detect.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_config(input logic [LIMIT_W-1:0] dz, input logic [ALPHA_W-1:0] al,
                              input logic [LIMIT_W-1:0] sk, input logic [LIMIT_W-1:0] aq);
    drain_frames();
    apb_write(REG_DEADZONE, DATA_W'(dz));
    apb_write(REG_ALPHA, DATA_W'(al));
    apb_write(REG_SKIP, DATA_W'(sk));
    apb_write(REG_ACQUIRE, DATA_W'(aq));
    apb_read(REG_DEADZONE, DATA_W'(dz));
    apb_read(REG_ALPHA, DATA_W'(al));
    apb_read(REG_SKIP, DATA_W'(sk));
    apb_read(REG_ACQUIRE, DATA_W'(aq));
  endtask

  task automatic offer_frame(input frame_item_t f);
    int gap;
    frame_ch.action   <= f.action;
    frame_ch.sample_0 <= f.smp[0];
    frame_ch.sample_1 <= f.smp[1];
    frame_ch.sample_2 <= f.smp[2];
    frame_ch.sample_3 <= f.smp[3];
    frame_ch.sample_4 <= f.smp[4];
    frame_ch.sample_5 <= f.smp[5];
    frame_ch.valid    <= 1'b1;
    do @(posedge clk); while (!frame_ch.ready);
    expected_detect.push_back(detect_frame(f));
    n_items++;
    if (f.action) n_recal++;
    @(negedge clk);
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic test_register_access();
    apb_read(REG_DEADZONE, DATA_W'(dz_cfg));
    apb_read(REG_ALPHA, DATA_W'(alpha_cfg));
    apb_read(REG_SKIP, DATA_W'(skip_cfg));
    apb_read(REG_ACQUIRE, DATA_W'(acq_cfg));
    write_config(10'd1023, 9'd511, 10'd1023, 10'd1023);
    write_config(10'd0, 9'd0, 10'd0, 10'd0);
  endtask

  task automatic test_directed_cases();
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
    write_config(10'd0, ALPHA_ONE, 10'd0, 10'd1);
    offer_frame(uniform_frame(1'b0, 10'h3FF));
    offer_frame(uniform_frame(1'b0, 10'h155));
    offer_frame(uniform_frame(1'b0, 10'h2AA));
    offer_frame(uniform_frame(1'b0, 10'h000));
    offer_frame(split_frame(6'b000001, 10'h000, 10'h3FF));
    offer_frame(split_frame(6'b100000, 10'h000, 10'h3FF));
    offer_frame(split_frame(6'b001100, 10'h000, 10'h3FF));
    offer_frame(uniform_frame(1'b0, 10'h154));
    offer_frame(uniform_frame(1'b0, 10'h155));
    offer_frame(uniform_frame(1'b1, 10'h3FF));
    offer_frame(uniform_frame(1'b0, 10'h000));
    // A deadzone above the minimum leaves the threshold negative.
    write_config(10'd1023, 9'd511, 10'd0, 10'd1);
    offer_frame(uniform_frame(1'b0, 10'h005));
    offer_frame(uniform_frame(1'b0, 10'h200));
    offer_frame(uniform_frame(1'b0, 10'h000));
    write_config(10'd0, 9'd0, 10'd0, 10'd1);
    offer_frame(uniform_frame(1'b1, 10'h000));
    repeat (3) offer_frame(uniform_frame(1'b0, 10'd300));
    offer_frame(uniform_frame(1'b0, 10'h000));
    write_config(10'd0, 9'd128, 10'd0, 10'd1);
    repeat (2) offer_frame(uniform_frame(1'b0, 10'h000));
  endtask

  task automatic test_limit_changes();
    write_config(10'd30, 9'd200, 10'd1023, 10'd1023);
    foreach (scene_base[i]) scene_base[i] = sample_t'($urandom_range(400, 1023));
    offer_frame(uniform_frame(1'b1, 10'h000));
    repeat (20) offer_frame(scene_frame());
    write_config(10'd30, 9'd200, 10'd5, 10'd1023);
    repeat (10) offer_frame(scene_frame());
    write_config(10'd30, 9'd200, 10'd5, 10'd2);
    repeat (10) offer_frame(scene_frame());
  endtask

  task automatic test_receiver_hold();
    drain_frames();
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (30) offer_frame(scene_frame());
    drain_frames();
  endtask

  task automatic test_random_scenes();
    for (int ph = 0; ph < SCENE_PHASES; ph++) begin
      case (ph)
        0: write_config(10'd0, ALPHA_ONE, 10'd0, 10'd0);
        1: write_config(10'd1023, 9'd511, 10'd1, 10'd2);
        2: write_config(10'd20, 9'd0, 10'd2, 10'd1);
        default: write_config(LIMIT_W'($urandom_range(0, 120)), ALPHA_W'($urandom_range(0, 300)),
                              LIMIT_W'($urandom_range(0, 4)), LIMIT_W'($urandom_range(0, 6)));
      endcase
      src_gaps = (ph % 3 != 2);
      snk_gaps = (ph % 4 != 3);
      foreach (scene_base[i]) scene_base[i] = sample_t'($urandom_range(200, 1023));
      offer_frame(uniform_frame(1'b1, sample_t'($urandom)));
      repeat (SCENE_FRAMES) offer_frame(scene_frame());
    end
  endtask

  always @(posedge clk) begin
    detect_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_detect.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("mismatch at %0t: result item with no frame outstanding", $time);
      end else begin
        want = expected_detect.pop_front();
        n_checked++;
        if (result_ch.trigger_mask !== want.mask)
          note_mismatch("trigger_mask", int'(want.mask), int'(result_ch.trigger_mask));
        if (result_ch.hand_position !== want.pos)
          note_mismatch("hand_position", int'(want.pos), int'(result_ch.hand_position));
        if (result_ch.all_calibrated !== want.allcal)
          note_mismatch("all_calibrated", int'(want.allcal), int'(result_ch.all_calibrated));
        if (want.mask != 0) n_trig++;
        if (want.allcal) n_allcal++;
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else if (snk_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    frame_ch.valid    = 1'b0;
    frame_ch.action   = 1'b0;
    frame_ch.sample_0 = '0;
    frame_ch.sample_1 = '0;
    frame_ch.sample_2 = '0;
    frame_ch.sample_3 = '0;
    frame_ch.sample_4 = '0;
    frame_ch.sample_5 = '0;
    dz_cfg            = '0;
    alpha_cfg         = ALPHA_ONE;
    skip_cfg          = 10'd8;
    acq_cfg           = 10'd64;
    clear_sensor_model();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_register_access();
    test_directed_cases();
    test_limit_changes();
    test_receiver_hold();
    test_random_scenes();

    drain_frames();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_detect.size() != 0) n_errors++;

    $display("summary: %0d frame items sent, %0d of them recalibrate, %0d register writes",
             n_items, n_recal, n_writes);
    $display("summary: %0d results checked, %0d with triggers, %0d fully calibrated, %0d errors",
             n_checked, n_trig, n_allcal, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
